// ===== sv/rac_pkg.sv =====
// ----------------------------------------------------------------------------
// rac_pkg: shared types and constants of the rational accumulator ALU
// Transaction payloads, mode and status codes, sequencer states and the
// widths of the wide magnitude datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rac_pkg;

  // Width of an operand field and of one operand magnitude.
  localparam int OP_W   = 32;
  // Width of a product or sum magnitude.
  localparam int WIDE_W = 64;
  // Width of the shared adder (one guard bit for division trials).
  localparam int SUM_W  = WIDE_W + 1;
  localparam int CNT_W  = $clog2(WIDE_W);
  localparam int DEN_OUT_W = 31;

  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [2:0] MODE_LOAD = 3'd0;
  localparam logic [2:0] MODE_ADD  = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;
  localparam logic [2:0] MODE_CMP  = 3'd5;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]             mode;
    logic signed [OP_W-1:0] operand_num;
    logic signed [OP_W-1:0] operand_den;
  } cmd_t;

  typedef struct packed {
    logic signed [OP_W-1:0] result_num;
    logic [DEN_OUT_W-1:0]   result_den;
    logic                   is_equal;
    logic [1:0]             status;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_ADD,
    ST_NEG,
    ST_GCD_INIT,
    ST_GCD_TWO,
    ST_GCD_A,
    ST_GCD_B,
    ST_DIV_N,
    ST_DIV_D,
    ST_FINISH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== sv/rac_mul.sv =====
// ----------------------------------------------------------------------------
// rac_mul: registered magnitude multiplier
// Multiplies two unsigned operand magnitudes; the product appears in the
// cycle after the operands are presented.
// ----------------------------------------------------------------------------
`default_nettype none

module rac_mul
  import rac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [OP_W-1:0]   a,
  input  wire logic [OP_W-1:0]   b,
  output logic      [WIDE_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= WIDE_W'(a) * WIDE_W'(b);
  end

endmodule

`default_nettype wire

// ===== sv/rac_addsub.sv =====
// ----------------------------------------------------------------------------
// rac_addsub: shared wide adder and subtractor
// Adds or subtracts two magnitudes. On a subtraction the carry is high
// when a is not less than b, so it doubles as the magnitude compare.
// ----------------------------------------------------------------------------
`default_nettype none

module rac_addsub
  import rac_pkg::*;
(
  input  wire logic [SUM_W-1:0] a,
  input  wire logic [SUM_W-1:0] b,
  input  wire logic             sub,
  output logic      [SUM_W-1:0] sum,
  output logic                  carry
);

  logic [SUM_W-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + (SUM_W + 1)'(sub);

endmodule

`default_nettype wire

// ===== sv/rational_accumulator_alu.sv =====
// ----------------------------------------------------------------------------
// rational_accumulator_alu: fraction accumulator with gcd reduction
// Holds one reduced fraction and loads, adds, subtracts, multiplies,
// divides or compares it against an operand fraction, one transaction at
// a time, through a shared multiplier and a shared wide adder.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   cmd     | in        | cmd_valid, cmd_stall | mode, operand_num/den
//   rsp     | out       | rsp_valid, rsp_stall | result, is_equal, status
//
// A rejected operand or an unused mode goes straight to the done state. Any
// other step with a nonzero result numerator runs the binary gcd loop on the
// 64-bit operands, one shift, subtract or swap per cycle, and then two 64-step
// restoring divisions, all on the one 65-bit adder. A zero result numerator
// skips reduction. cmd_stall is high whenever the sequencer is busy. A
// finished result waits in the output register while rsp_stall is high; a
// new command is still taken meanwhile. Reset leaves the accumulator at 0/1
// and the output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_accumulator_alu
  import rac_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam logic [WIDE_W-1:0] LIM    = WIDE_W'(1) << (VALUE_WIDTH - 1);
  localparam logic [WIDE_W-1:0] LIM_M1 = LIM - WIDE_W'(1);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(WIDE_W - 1);

  state_t state, state_next;

  // Accumulator, always held in lowest terms.
  logic signed [VALUE_WIDTH-1:0] acc_num;
  logic        [VALUE_WIDTH-2:0] acc_den;

  // Latched operand, denominator sign already folded into the numerator.
  logic [2:0]      mode_q;
  logic            on_neg;
  logic [OP_W-1:0] on_mag;
  logic [OP_W-1:0] od_mag;

  // Working fraction and product registers.
  logic [WIDE_W-1:0] p1, p2;
  logic              s1, s2;
  logic              neg;
  logic [WIDE_W-1:0] n_mag, d_mag;
  logic [WIDE_W-1:0] ga, gb;
  logic [WIDE_W-1:0] rem, quo;
  logic [CNT_W-1:0]  cnt;
  logic              res_eq;
  logic [1:0]        res_status;

  // Decoded input and accumulator views.
  logic [OP_W-1:0] in_num_u, in_den_u;
  logic [OP_W-1:0] in_num_mag, in_den_mag;
  logic            in_neg;
  logic [OP_W-1:0] an_ext, an_mag, ad_mag;
  logic            an_neg;

  // Shared units.
  logic [OP_W-1:0]   mul_a, mul_b;
  logic [WIDE_W-1:0] prod;
  logic [SUM_W-1:0]  add_a, add_b, add_sum;
  logic              add_sub, add_carry;

  logic [SUM_W-1:0]  trial;
  logic [WIDE_W-1:0] quo_shift;
  logic              out_free;
  logic              fit;
  logic              cmp_match;
  logic [VALUE_WIDTH-1:0] n_trunc;

  assign in_num_u   = cmd.operand_num;
  assign in_den_u   = cmd.operand_den;
  assign in_num_mag = in_num_u[OP_W-1] ? (~in_num_u + OP_W'(1)) : in_num_u;
  assign in_den_mag = in_den_u[OP_W-1] ? (~in_den_u + OP_W'(1)) : in_den_u;
  // A negative denominator flips the sign of a nonzero numerator.
  assign in_neg = in_den_u[OP_W-1] ? ((in_num_mag != '0) && !in_num_u[OP_W-1])
                                   : in_num_u[OP_W-1];

  assign an_neg = acc_num[VALUE_WIDTH-1];
  assign an_ext = OP_W'(acc_num);
  assign an_mag = an_neg ? (~an_ext + OP_W'(1)) : an_ext;
  assign ad_mag = OP_W'(acc_den);

  assign trial     = {rem, quo[WIDE_W-1]};
  assign quo_shift = {quo[WIDE_W-2:0], add_carry};
  assign out_free  = !rsp_valid || !rsp_stall;
  assign n_trunc   = n_mag[VALUE_WIDTH-1:0];

  assign fit = (d_mag <= LIM_M1) && (neg ? (n_mag <= LIM) : (n_mag <= LIM_M1));
  assign cmp_match = (n_mag == WIDE_W'(an_mag)) && (d_mag == WIDE_W'(ad_mag)) &&
                     ((neg && (n_mag != '0)) == an_neg);

  rac_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rac_addsub u_addsub (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit operand selection.
  always_comb begin
    state_next = state;
    cmd_stall  = (state != ST_IDLE);
    mul_a      = ad_mag;
    mul_b      = od_mag;
    add_a      = '0;
    add_b      = '0;
    add_sub    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if ((cmd.mode <= MODE_CMP) && (in_den_mag == '0)) begin
            state_next = ST_DONE;
          end else begin
            case (cmd.mode)
              MODE_LOAD, MODE_CMP: state_next = ST_GCD_INIT;
              MODE_ADD, MODE_SUB, MODE_MUL: state_next = ST_MUL1;
              MODE_DIV: state_next = (in_num_mag == '0) ? ST_DONE : ST_MUL1;
              default: state_next = ST_DONE;
            endcase
          end
        end
      end
      ST_MUL1: begin
        mul_a = an_mag;
        mul_b = (mode_q == MODE_MUL) ? on_mag : od_mag;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        case (mode_q)
          MODE_MUL: begin
            mul_a = ad_mag;
            mul_b = od_mag;
          end
          MODE_DIV: begin
            mul_a = ad_mag;
            mul_b = on_mag;
          end
          default: begin
            mul_a = on_mag;
            mul_b = ad_mag;
          end
        endcase
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        if ((mode_q == MODE_ADD) || (mode_q == MODE_SUB)) begin
          state_next = ST_MUL4;
        end else begin
          state_next = ST_GCD_INIT;
        end
      end
      ST_MUL4: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        add_a   = SUM_W'(p1);
        add_b   = SUM_W'(p2);
        add_sub = (s1 != s2);
        if ((s1 != s2) && !add_carry) begin
          state_next = ST_NEG;
        end else begin
          state_next = ST_GCD_INIT;
        end
      end
      ST_NEG: begin
        add_b      = SUM_W'(n_mag);
        add_sub    = 1'b1;
        state_next = ST_GCD_INIT;
      end
      ST_GCD_INIT: begin
        state_next = (n_mag == '0) ? ST_FINISH : ST_GCD_TWO;
      end
      ST_GCD_TWO: begin
        if (ga[0] || gb[0]) begin
          state_next = ST_GCD_A;
        end
      end
      ST_GCD_A: begin
        if (ga[0]) begin
          state_next = ST_GCD_B;
        end
      end
      ST_GCD_B: begin
        add_a   = SUM_W'(gb);
        add_b   = SUM_W'(ga);
        add_sub = 1'b1;
        if (gb == '0) begin
          state_next = ST_DIV_N;
        end
      end
      ST_DIV_N: begin
        add_a   = trial;
        add_b   = SUM_W'(ga);
        add_sub = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        add_a   = trial;
        add_b   = SUM_W'(ga);
        add_sub = 1'b1;
        if (cnt == CNT_LAST) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Accumulator and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num   <= '0;
      acc_den   <= (VALUE_WIDTH - 1)'(1);
      rsp_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if ((state == ST_FINISH) && (mode_q != MODE_CMP) && fit) begin
        acc_num <= neg ? ((~n_trunc) + VALUE_WIDTH'(1)) : n_trunc;
        acc_den <= d_mag[VALUE_WIDTH-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      rsp.result_num <= OP_W'(acc_num);
      rsp.result_den <= DEN_OUT_W'(acc_den);
      rsp.is_equal   <= res_eq;
      rsp.status     <= res_status;
    end
  end

  // Working datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        mode_q     <= cmd.mode;
        on_neg     <= in_neg;
        on_mag     <= in_num_mag;
        od_mag     <= in_den_mag;
        n_mag      <= WIDE_W'(in_num_mag);
        d_mag      <= WIDE_W'(in_den_mag);
        neg        <= in_neg;
        res_eq     <= 1'b0;
        if ((cmd.mode <= MODE_CMP) && (in_den_mag == '0)) begin
          res_status <= STATUS_ZERO;
        end else if ((cmd.mode == MODE_DIV) && (in_num_mag == '0)) begin
          res_status <= STATUS_ZERO;
        end else begin
          res_status <= STATUS_OK;
        end
      end
      ST_MUL2: begin
        p1 <= prod;
        if ((mode_q == MODE_ADD) || (mode_q == MODE_SUB)) begin
          s1 <= an_neg;
        end else begin
          s1 <= an_neg ^ on_neg;
        end
      end
      ST_MUL3: begin
        p2 <= prod;
        s2 <= on_neg ^ (mode_q == MODE_SUB);
        // Multiply and divide: the two products are the new fraction.
        n_mag <= p1;
        d_mag <= prod;
        neg   <= s1;
      end
      ST_MUL4: begin
        d_mag <= prod;
      end
      ST_ADD: begin
        n_mag <= add_sum[WIDE_W-1:0];
        neg   <= ((s1 != s2) && !add_carry) ? s2 : s1;
      end
      ST_NEG: begin
        n_mag <= add_sum[WIDE_W-1:0];
      end
      ST_GCD_INIT: begin
        ga <= n_mag;
        gb <= d_mag;
        // A zero numerator is kept as 0/1 without reduction.
        if (n_mag == '0) begin
          d_mag <= WIDE_W'(1);
          neg   <= 1'b0;
        end
      end
      ST_GCD_TWO: begin
        // Common factors of two are stripped from the fraction directly.
        if (!(ga[0] || gb[0])) begin
          ga    <= ga >> 1;
          gb    <= gb >> 1;
          n_mag <= n_mag >> 1;
          d_mag <= d_mag >> 1;
        end
      end
      ST_GCD_A: begin
        if (!ga[0]) begin
          ga <= ga >> 1;
        end
      end
      ST_GCD_B: begin
        if (gb == '0) begin
          quo <= n_mag;
          rem <= '0;
          cnt <= '0;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (add_carry) begin
          gb <= add_sum[WIDE_W-1:0];
        end else begin
          ga <= gb;
          gb <= ga;
        end
      end
      ST_DIV_N: begin
        if (cnt == CNT_LAST) begin
          n_mag <= quo_shift;
          quo   <= d_mag;
          rem   <= '0;
          cnt   <= '0;
        end else begin
          rem <= add_carry ? add_sum[WIDE_W-1:0] : trial[WIDE_W-1:0];
          quo <= quo_shift;
          cnt <= cnt + CNT_W'(1);
        end
      end
      ST_DIV_D: begin
        rem <= add_carry ? add_sum[WIDE_W-1:0] : trial[WIDE_W-1:0];
        quo <= quo_shift;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          d_mag <= quo_shift;
        end
      end
      ST_FINISH: begin
        if (mode_q == MODE_CMP) begin
          res_eq <= cmp_match;
        end else if (!fit) begin
          res_status <= STATUS_OVF;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
